[sv/csrc_pkg.sv]
// Shared constants, codes and helpers for the clip rectangle stack clipper.
package csrc_pkg;

  // Default stack depth and field widths
  localparam int STACK_DEPTH_DEF = 16;
  localparam int COORD_W = 16;
  localparam int EDGE_W = 13;
  localparam int LEVEL_W = 5;
  localparam int ENTRY_W = 4 * COORD_W;
  localparam int WIDE_W = 18;

  // Register reset values
  localparam logic [EDGE_W-1:0] FRAME_W_RST = 13'd640;
  localparam logic [EDGE_W-1:0] FRAME_H_RST = 13'd480;

  // Request codes
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP = 2'd1;
  localparam logic [1:0] REQ_CLIP = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FRAME_W = 1'b0;
  localparam logic CFG_FRAME_H = 1'b1;

  typedef logic signed [WIDE_W-1:0] wide_t;

  // min(hi, max(v, lo)); hi wins when lo > hi
  function automatic wide_t clamp_edge(input wide_t v, input wide_t lo, input wide_t hi);
    wide_t t;
    t = (v < lo) ? lo : v;
    return (hi < t) ? hi : t;
  endfunction

endpackage

[sv/csrc_store.sv]
// Clip rectangle store: single write port, one registered read port.
module csrc_store #(
  parameter int DEPTH = csrc_pkg::STACK_DEPTH_DEF,
  parameter int AW = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [csrc_pkg::ENTRY_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic [csrc_pkg::ENTRY_W-1:0] rd_data
);

  logic [csrc_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [csrc_pkg::ENTRY_W-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/clip_stack_rect_clipper.sv]
// Clip rectangle stack clipper: push/pop a stack of clips, clip draw rectangles.
// Sequence: push, pop and unknown requests go from accept to ST_POST; a clip request
// steps ST_WALK once per stack entry (one store read per entry), then ST_FINAL and ST_POST.
// One item at a time: the next item is taken the cycle after the result is latched into the
// output register, which waits in ST_POST until out_valid is low or out_ready is high.
// Reset: stack empty, frame 640 x 480; store contents stay undefined (no clearing pass).
module clip_stack_rect_clipper #(
  parameter int STACK_DEPTH = csrc_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [csrc_pkg::EDGE_W-1:0]         cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic signed [csrc_pkg::COORD_W-1:0] in_rect_x,
  input  logic signed [csrc_pkg::COORD_W-1:0] in_rect_y,
  input  logic signed [csrc_pkg::COORD_W-1:0] in_rect_w,
  input  logic signed [csrc_pkg::COORD_W-1:0] in_rect_h,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csrc_pkg::EDGE_W-1:0]         out_clip_left,
  output logic [csrc_pkg::EDGE_W-1:0]         out_clip_top,
  output logic [csrc_pkg::EDGE_W-1:0]         out_clip_right,
  output logic [csrc_pkg::EDGE_W-1:0]         out_clip_bottom,
  output logic                                out_nothing_to_draw,
  output logic                                out_request_done,
  output logic [csrc_pkg::LEVEL_W-1:0]        out_stack_level
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = csrc_pkg::EDGE_W;
  localparam int WW = csrc_pkg::WIDE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_POST  = 4'b1000
  } state_t;

  state_t st_r, st_nxt;

  logic [EW-1:0] fw_r, fh_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] d_r, d_nxt, d_inc;

  // latched draw rectangle
  logic signed [csrc_pkg::COORD_W-1:0] rx_r, ry_r, rw_r, rh_r;

  // effective clip window
  logic [EW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [EW-1:0] x0_nxt, y0_nxt, x1_nxt, y1_nxt;

  // pending result
  logic [EW-1:0] res_l_r, res_t_r, res_r_r, res_b_r;
  logic [EW-1:0] res_l_nxt, res_t_nxt, res_r_nxt, res_b_nxt;
  logic res_empty_r, res_empty_nxt, res_done_r, res_done_nxt;
  logic [csrc_pkg::LEVEL_W-1:0] res_level_r, res_level_nxt;

  // output register
  logic out_valid_r;
  logic [EW-1:0] out_l_r, out_t_r, out_r_r, out_b_r;
  logic out_empty_r, out_done_r;
  logic [csrc_pkg::LEVEL_W-1:0] out_level_r;

  // store interface
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [csrc_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic in_acc, post_go;

  csrc_store #(
    .DEPTH(STACK_DEPTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .wr_en(mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign in_ready = (st_r == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign post_go = (st_r == ST_POST) && (!out_valid_r || out_ready);
  assign d_inc = d_r + 1'b1;

  // push writes the entry on top of the stack at accept
  assign mem_we = in_acc && (in_req_type == csrc_pkg::REQ_PUSH) && (count_r < DEPTH_C);
  assign mem_waddr = count_r[AW-1:0];
  assign mem_wdata = {in_rect_h, in_rect_w, in_rect_y, in_rect_x};
  assign mem_raddr = (st_r == ST_WALK) ? d_inc[AW-1:0] : '0;

  // per-entry clamp to the frame, intersected with the window
  logic signed [csrc_pkg::COORD_W-1:0] cx, cy, cw, ch;
  csrc_pkg::wide_t fw_w, fh_w, cx0, cy0, cx1, cy1;

  always_comb begin
    cx = mem_rdata[15:0];
    cy = mem_rdata[31:16];
    cw = mem_rdata[47:32];
    ch = mem_rdata[63:48];
    fw_w = csrc_pkg::wide_t'({1'b0, fw_r});
    fh_w = csrc_pkg::wide_t'({1'b0, fh_r});
    cx0 = csrc_pkg::clamp_edge(WW'(cx), '0, fw_w);
    cy0 = csrc_pkg::clamp_edge(WW'(cy), '0, fh_w);
    cx1 = csrc_pkg::clamp_edge(WW'(cx) + WW'(cw), '0, fw_w);
    cy1 = csrc_pkg::clamp_edge(WW'(cy) + WW'(ch), '0, fh_w);
  end

  // final clamp of the draw rectangle
  csrc_pkg::wide_t a0, b0, a1, b1;
  logic draw_empty;

  always_comb begin
    a0 = csrc_pkg::clamp_edge(WW'(rx_r), WW'({1'b0, x0_r}), WW'({1'b0, x1_r}));
    b0 = csrc_pkg::clamp_edge(WW'(ry_r), WW'({1'b0, y0_r}), WW'({1'b0, y1_r}));
    a1 = csrc_pkg::clamp_edge(WW'(rx_r) + WW'(rw_r), WW'({1'b0, x0_r}),
                              WW'({1'b0, x1_r}));
    b1 = csrc_pkg::clamp_edge(WW'(ry_r) + WW'(rh_r), WW'({1'b0, y0_r}),
                              WW'({1'b0, y1_r}));
    draw_empty = (rw_r <= 0) || (rh_r <= 0) || (a0 >= a1) || (b0 >= b1);
  end

  function automatic logic [csrc_pkg::LEVEL_W-1:0] LEVEL_W_CAST(input logic [CW-1:0] c);
    return csrc_pkg::LEVEL_W'(c);
  endfunction

  // sequencer
  always_comb begin
    st_nxt = st_r;
    count_nxt = count_r;
    d_nxt = d_r;
    x0_nxt = x0_r;
    y0_nxt = y0_r;
    x1_nxt = x1_r;
    y1_nxt = y1_r;
    res_l_nxt = res_l_r;
    res_t_nxt = res_t_r;
    res_r_nxt = res_r_r;
    res_b_nxt = res_b_r;
    res_empty_nxt = res_empty_r;
    res_done_nxt = res_done_r;
    res_level_nxt = res_level_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_l_nxt = '0;
          res_t_nxt = '0;
          res_r_nxt = '0;
          res_b_nxt = '0;
          res_empty_nxt = 1'b1;
          res_done_nxt = 1'b0;
          st_nxt = ST_POST;
          case (in_req_type)
            csrc_pkg::REQ_PUSH: begin
              if (count_r < DEPTH_C) begin
                count_nxt = count_r + 1'b1;
                res_done_nxt = 1'b1;
              end
            end
            csrc_pkg::REQ_POP: begin
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
                res_done_nxt = 1'b1;
              end
            end
            csrc_pkg::REQ_CLIP: begin
              x0_nxt = '0;
              y0_nxt = '0;
              x1_nxt = fw_r;
              y1_nxt = fh_r;
              d_nxt = '0;
              st_nxt = (count_r == '0) ? ST_FINAL : ST_WALK;
            end
            default: begin
              // unknown request: ignored
            end
          endcase
          res_level_nxt = LEVEL_W_CAST(count_nxt);
        end
      end
      ST_WALK: begin
        if (cx0[EW-1:0] > x0_r) x0_nxt = cx0[EW-1:0];
        if (cy0[EW-1:0] > y0_r) y0_nxt = cy0[EW-1:0];
        if (cx1[EW-1:0] < x1_r) x1_nxt = cx1[EW-1:0];
        if (cy1[EW-1:0] < y1_r) y1_nxt = cy1[EW-1:0];
        d_nxt = d_inc;
        if (d_inc == count_r) st_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        res_l_nxt = a0[EW-1:0];
        res_t_nxt = b0[EW-1:0];
        res_r_nxt = a1[EW-1:0];
        res_b_nxt = b1[EW-1:0];
        res_empty_nxt = draw_empty;
        res_done_nxt = 1'b1;
        res_level_nxt = LEVEL_W_CAST(count_r);
        st_nxt = ST_POST;
      end
      ST_POST: begin
        if (post_go) st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= '0;
      fw_r <= csrc_pkg::FRAME_W_RST;
      fh_r <= csrc_pkg::FRAME_H_RST;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          csrc_pkg::CFG_FRAME_W: fw_r <= cfg_data;
          csrc_pkg::CFG_FRAME_H: fh_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (post_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    x0_r <= x0_nxt;
    y0_r <= y0_nxt;
    x1_r <= x1_nxt;
    y1_r <= y1_nxt;
    res_l_r <= res_l_nxt;
    res_t_r <= res_t_nxt;
    res_r_r <= res_r_nxt;
    res_b_r <= res_b_nxt;
    res_empty_r <= res_empty_nxt;
    res_done_r <= res_done_nxt;
    res_level_r <= res_level_nxt;
    if (in_acc) begin
      rx_r <= in_rect_x;
      ry_r <= in_rect_y;
      rw_r <= in_rect_w;
      rh_r <= in_rect_h;
    end
    if (post_go) begin
      out_l_r <= res_l_r;
      out_t_r <= res_t_r;
      out_r_r <= res_r_r;
      out_b_r <= res_b_r;
      out_empty_r <= res_empty_r;
      out_done_r <= res_done_r;
      out_level_r <= res_level_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_clip_left = out_l_r;
  assign out_clip_top = out_t_r;
  assign out_clip_right = out_r_r;
  assign out_clip_bottom = out_b_r;
  assign out_nothing_to_draw = out_empty_r;
  assign out_request_done = out_done_r;
  assign out_stack_level = out_level_r;

endmodule
